// ===== design/tcw_pkg.sv =====
// Shared constants, types and codes of the text console cell writer.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int COORD_W = 8;
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 2 * BYTE_W;

  localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [BYTE_W-1:0] CHAR_ERROR     = 8'h45;
  localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;

  localparam logic [BYTE_W-1:0] NORMAL_COLOR_RESET = 8'd15;
  localparam logic [BYTE_W-1:0] ERROR_COLOR_RESET  = 8'd79;

  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } tcw_cmd_t;

  typedef enum logic {
    REG_NORMAL_COLOR = 1'b0,
    REG_ERROR_COLOR  = 1'b1
  } tcw_reg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN,
    ST_ZERO,
    ST_CLEAR
  } tcw_state_t;

  // Control of the shared cell index counter.
  typedef struct packed {
    logic  load;
    cell_t start_val;
    logic  step;
    cell_t end_val;
  } tcw_sweep_ctl_t;

endpackage

// ===== design/tcw_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tcw_sweep.sv =====
// Shared cell index counter that walks the screen store for fills and scrolls.
`timescale 1ns / 1ps

module tcw_sweep (
  input  logic                    clk,
  input  logic                    rst,
  input  tcw_pkg::tcw_sweep_ctl_t ctl,
  output tcw_pkg::cell_t          idx,
  output logic                    at_end
);

  tcw_pkg::cell_t idx_next;

  always_comb begin
    priority if (ctl.load) begin
      idx_next = ctl.start_val;
    end else if (ctl.step) begin
      idx_next = idx + tcw_pkg::CELL_W'(1);
    end else begin
      idx_next = idx;
    end
  end

  assign at_end = (idx == ctl.end_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

endmodule

// ===== design/text_console_cell_writer_core.sv =====
// Top level of the text console cell writer: sequencer, cursor and result registers.
`timescale 1ns / 1ps

// A character-cell console of 80 x 25 cells, each a character byte and an
// attribute byte, with a cursor. An item is accepted when start is high and
// busy is low; the command and its fields are sampled at that edge. Every
// item produces one result, shown on the result ports for one cycle while
// done is high. The receiver cannot stall, and busy may already be low while
// done is high, so the next item can be accepted in that same cycle.
// States passed from the accept edge until the next item can be accepted:
//   put without scroll, unused command, out-of-range read: ST_EXEC only
//   read of a cell: ST_EXEC, ST_READ (one registered RAM read)
//   put that scrolls: ST_EXEC, ST_SCROLL, ST_DRAIN, ST_ZERO (copy, drain, zero last row)
//   clear: ST_EXEC, ST_CLEAR (fill with spaces in the normal color)
// The single cell index counter walking the one-port-write store sets the
// length of clears and scrolls.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high. After reset the block fills the store with
// spaces in the reset normal color while busy stays high.

module text_console_cell_writer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [7:0]  column,
  input  logic [7:0]  line_index,
  input  logic        at_cursor,
  input  logic [7:0]  attribute,
  output logic        done,
  output logic [10:0] cursor_cell,
  output logic        range_error,
  output logic [7:0]  read_char,
  output logic [7:0]  read_attr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam tcw_pkg::cell_t LAST_CELL  = tcw_pkg::CELL_W'(tcw_pkg::CELLS - 1);
  localparam tcw_pkg::cell_t LAST_ROW0  = tcw_pkg::CELL_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
  localparam tcw_pkg::cell_t COLS_CELL  = tcw_pkg::CELL_W'(tcw_pkg::COLUMNS);
  localparam tcw_pkg::coord_t COLS_C    = tcw_pkg::COORD_W'(tcw_pkg::COLUMNS);
  localparam tcw_pkg::coord_t ROWS_C    = tcw_pkg::COORD_W'(tcw_pkg::ROWS);

  tcw_pkg::tcw_state_t state, state_next;

  logic [7:0] normal_color;
  logic [7:0] error_color;

  // Item fields captured at the accept edge.
  tcw_pkg::tcw_cmd_t item_cmd;
  logic [7:0]        item_char;
  tcw_pkg::coord_t   item_col;
  tcw_pkg::coord_t   item_row;
  logic              item_at_cursor;
  logic [7:0]        item_attr;

  tcw_pkg::cell_t  cur_pos, cur_pos_next;
  tcw_pkg::coord_t cur_row, cur_row_next;
  tcw_pkg::coord_t cur_col, cur_col_next;

  logic           pend_valid, pend_valid_next;
  tcw_pkg::cell_t pend_addr, pend_addr_next;

  logic                          ram_we;
  tcw_pkg::cell_t                ram_waddr;
  logic [tcw_pkg::WORD_W-1:0]    ram_wdata;
  logic                          ram_re;
  tcw_pkg::cell_t                ram_raddr;
  logic [tcw_pkg::WORD_W-1:0]    ram_rdata;

  tcw_pkg::tcw_sweep_ctl_t sweep_ctl;
  tcw_pkg::cell_t          sweep_idx;
  logic                    sweep_end;

  logic res_fire;
  logic res_rerr;
  logic res_from_ram;

  logic            bad;
  tcw_pkg::coord_t cell_row;
  tcw_pkg::coord_t cell_col;
  tcw_pkg::cell_t  tgt_cell;
  logic [7:0]      eff_attr;
  tcw_pkg::coord_t row_inc;
  tcw_pkg::coord_t col_inc;

  tcw_ram #(
    .WIDTH(tcw_pkg::WORD_W),
    .DEPTH(tcw_pkg::CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tcw_sweep u_sweep (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sweep_ctl),
    .idx   (sweep_idx),
    .at_end(sweep_end)
  );

  assign busy      = (state != tcw_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Target cell of the current item.
  assign bad = !item_at_cursor && ((item_col >= COLS_C) || (item_row >= ROWS_C));
  assign cell_row = item_at_cursor ? cur_row : item_row;
  assign cell_col = item_at_cursor ? cur_col : item_col;
  assign tgt_cell = item_at_cursor ? cur_pos
                  : tcw_pkg::CELL_W'(tcw_pkg::CELL_W'(item_row) * COLS_CELL)
                    + tcw_pkg::CELL_W'(item_col);
  assign eff_attr = (item_attr == 8'd0) ? normal_color : item_attr;
  assign row_inc  = cell_row + tcw_pkg::COORD_W'(1);
  assign col_inc  = cell_col + tcw_pkg::COORD_W'(1);

  always_comb begin
    state_next      = state;
    cur_pos_next    = cur_pos;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    pend_valid_next = pend_valid;
    pend_addr_next  = pend_addr;
    ram_we          = 1'b0;
    ram_waddr       = tgt_cell;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = tgt_cell;
    sweep_ctl       = '{load: 1'b0, start_val: '0, step: 1'b0, end_val: LAST_CELL};
    res_fire        = 1'b0;
    res_rerr        = 1'b0;
    res_from_ram    = 1'b0;

    unique case (state)
      tcw_pkg::ST_INIT: begin
        ram_we         = 1'b1;
        ram_waddr      = sweep_idx;
        ram_wdata      = {tcw_pkg::NORMAL_COLOR_RESET, tcw_pkg::CHAR_SPACE};
        sweep_ctl.step = 1'b1;
        if (sweep_end) begin
          sweep_ctl.load = 1'b1;
          state_next     = tcw_pkg::ST_IDLE;
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (start) begin
          state_next = tcw_pkg::ST_EXEC;
        end
      end

      tcw_pkg::ST_EXEC: begin
        state_next = tcw_pkg::ST_IDLE;
        unique case (item_cmd)
          tcw_pkg::CMD_PUT: begin
            if (bad) begin
              ram_we    = 1'b1;
              ram_waddr = LAST_CELL;
              ram_wdata = {error_color, tcw_pkg::CHAR_ERROR};
              res_fire  = 1'b1;
              res_rerr  = 1'b1;
            end else begin
              priority if (item_char == tcw_pkg::CHAR_NEWLINE) begin
                cur_row_next = row_inc;
                cur_col_next = '0;
                cur_pos_next = tgt_cell - tcw_pkg::CELL_W'(cell_col) + COLS_CELL;
              end else if (item_char == tcw_pkg::CHAR_BACKSPACE) begin
                ram_we       = 1'b1;
                ram_wdata    = {eff_attr, tcw_pkg::CHAR_SPACE};
                cur_row_next = cell_row;
                cur_col_next = cell_col;
                cur_pos_next = tgt_cell;
              end else begin
                ram_we       = 1'b1;
                ram_wdata    = {eff_attr, item_char};
                cur_pos_next = tgt_cell + tcw_pkg::CELL_W'(1);
                if (col_inc == COLS_C) begin
                  cur_row_next = row_inc;
                  cur_col_next = '0;
                end else begin
                  cur_row_next = cell_row;
                  cur_col_next = col_inc;
                end
              end
              // Running past the last row scrolls the screen up by one row.
              if ((item_char != tcw_pkg::CHAR_BACKSPACE) && (cur_row_next == ROWS_C)) begin
                cur_row_next        = ROWS_C - tcw_pkg::COORD_W'(1);
                cur_pos_next        = LAST_ROW0;
                sweep_ctl.load      = 1'b1;
                sweep_ctl.start_val = COLS_CELL;
                state_next          = tcw_pkg::ST_SCROLL;
              end else begin
                res_fire = 1'b1;
              end
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            cur_pos_next        = '0;
            cur_row_next        = '0;
            cur_col_next        = '0;
            sweep_ctl.load      = 1'b1;
            sweep_ctl.start_val = '0;
            state_next          = tcw_pkg::ST_CLEAR;
          end
          tcw_pkg::CMD_READ: begin
            if (bad) begin
              res_fire = 1'b1;
              res_rerr = 1'b1;
            end else begin
              ram_re     = 1'b1;
              state_next = tcw_pkg::ST_READ;
            end
          end
          tcw_pkg::CMD_NONE: begin
            res_fire = 1'b1;
          end
        endcase
      end

      tcw_pkg::ST_READ: begin
        res_fire     = 1'b1;
        res_from_ram = 1'b1;
        state_next   = tcw_pkg::ST_IDLE;
      end

      tcw_pkg::ST_SCROLL: begin
        // Read one row below, write the previous read one row up.
        ram_re          = 1'b1;
        ram_raddr       = sweep_idx;
        ram_we          = pend_valid;
        ram_waddr       = pend_addr;
        ram_wdata       = ram_rdata;
        pend_valid_next = 1'b1;
        pend_addr_next  = sweep_idx - COLS_CELL;
        sweep_ctl.step  = 1'b1;
        if (sweep_end) begin
          state_next = tcw_pkg::ST_DRAIN;
        end
      end

      tcw_pkg::ST_DRAIN: begin
        ram_we              = 1'b1;
        ram_waddr           = pend_addr;
        ram_wdata           = ram_rdata;
        pend_valid_next     = 1'b0;
        sweep_ctl.load      = 1'b1;
        sweep_ctl.start_val = LAST_ROW0;
        state_next          = tcw_pkg::ST_ZERO;
      end

      tcw_pkg::ST_ZERO: begin
        ram_we         = 1'b1;
        ram_waddr      = sweep_idx;
        ram_wdata      = '0;
        sweep_ctl.step = 1'b1;
        if (sweep_end) begin
          res_fire   = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end

      tcw_pkg::ST_CLEAR: begin
        ram_we         = 1'b1;
        ram_waddr      = sweep_idx;
        ram_wdata      = {normal_color, tcw_pkg::CHAR_SPACE};
        sweep_ctl.step = 1'b1;
        if (sweep_end) begin
          res_fire   = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_color <= tcw_pkg::NORMAL_COLOR_RESET;
      error_color  <= tcw_pkg::ERROR_COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tcw_pkg::tcw_reg_t'(cfg_index))
        tcw_pkg::REG_NORMAL_COLOR: normal_color <= cfg_data;
        tcw_pkg::REG_ERROR_COLOR:  error_color  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pos    <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      cur_pos    <= cur_pos_next;
      cur_row    <= cur_row_next;
      cur_col    <= cur_col_next;
      pend_valid <= pend_valid_next;
      done       <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    if (start && !busy) begin
      item_cmd       <= tcw_pkg::tcw_cmd_t'(command);
      item_char      <= char_code;
      item_col       <= column;
      item_row       <= line_index;
      item_at_cursor <= at_cursor;
      item_attr      <= attribute;
    end
    if (res_fire) begin
      cursor_cell <= cur_pos_next;
      range_error <= res_rerr;
      read_char   <= res_from_ram ? ram_rdata[tcw_pkg::BYTE_W-1:0] : 8'd0;
      read_attr   <= res_from_ram ? ram_rdata[tcw_pkg::WORD_W-1:tcw_pkg::BYTE_W] : 8'd0;
    end
  end

endmodule
